[rtl/uos_pkg.sv]
// ----------------------------------------------------------------------------
// uos_pkg
// shared constants, types and tables for the unicycle odometry step block
// ----------------------------------------------------------------------------
package uos_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 24;
  localparam int ST_W          = FRAC_BITS + 1;          // sample time width
  localparam int CW            = 34;                     // cordic datapath width
  localparam int MA_W          = 34;                     // multiplier operand a
  localparam int MB_W          = 32;                     // multiplier operand b
  localparam int MP_W          = MA_W + MB_W;            // product width
  localparam int DIV_W         = 33 + FRAC_BITS;         // dividend magnitude
  localparam int T_W           = 32 + ST_W + 1;          // omega * ts width
  localparam int ACC_W         = T_W + 31;               // turn product width
  localparam int STEP_W        = $clog2(CORDIC_STAGES + 1);
  localparam int DCNT_W        = $clog2(DIV_W + 1);

  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
  localparam logic [31:0] RAD_TO_ANGLE    = 32'd683565276;
  localparam logic [ST_W-1:0] TS_RESET    = ST_W'(6554);

  typedef enum logic [2:0] {
    REG_SAMPLE_TIME   = 3'd0,
    REG_INIT_X        = 3'd1,
    REG_INIT_Y        = 3'd2,
    REG_INIT_HEADING  = 3'd3,
    REG_INIT_LIN_VEL  = 3'd4,
    REG_INIT_ANG_VEL  = 3'd5,
    REG_INIT_THROTTLE = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ROT, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9,
    S_M10, S_WAIT, S_FIN
  } state_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] k);
    logic [31:0] v;
    case (k)
      5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;  5'd31: v = 32'h00000000;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [39:0] v);
    logic [31:0] r;
    if (v > 40'sh007FFFFFFF) r = 32'h7FFFFFFF;
    else if (v < -40'sh0080000000) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[rtl/unicycle_odometry_step.sv]
// ----------------------------------------------------------------------------
// unicycle_odometry_step
// forward-euler differential-drive pose step with cordic, shared multiplier
// ----------------------------------------------------------------------------
// timing: a step transaction is set by the bit-serial throttle divider
//   (the cordic, and the ten multiplier steps after it, run beside it); a
//   restore transaction goes from idle straight to the finish state
// throughput: one transaction at a time, in_ready only while idle
// reset: synchronous, clears the pose to the init register reset values,
//   sample_time to 6554, all init registers to zero
module unicycle_odometry_step (
  input  logic        clk,
  input  logic        rst,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic signed [31:0] speed,
  input  logic signed [31:0] omega,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [31:0] heading,
  output logic signed [31:0] lin_vel,
  output logic signed [31:0] ang_vel,
  output logic signed [31:0] throttle
);
  import uos_pkg::*;

  // configuration registers
  logic [ST_W-1:0] sample_time;
  logic [31:0] init_x, init_y, init_heading, init_lin_vel, init_ang_vel, init_throttle;

  state_t state, state_next;

  // latched command of the transaction in flight
  logic signed [31:0] cmd_speed, cmd_omega;
  logic               restore;

  // datapath scratch
  logic signed [CW-1:0]   px;
  logic signed [31:0]     x_new, y_new;
  logic [31:0]            hd_new;
  logic                   t_neg;
  logic [T_W-2:0]         t_mag;
  logic [ACC_W-1:0]       acc;
  logic                   d_neg;

  logic [ST_W-1:0]        ts;
  logic                   acc_in, commit, cfg_wr;
  logic                   start_unit;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] prod;

  logic                   cor_busy, div_busy;
  logic signed [CW-1:0]   cos_v, sin_v;
  logic [DIV_W-1:0]       quot;

  // speed change magnitude, shifted up into the dividend
  logic signed [32:0]     diff;
  logic [32:0]            diff_mag;
  logic [DIV_W-1:0]       dividend;

  // rounded intermediate values
  logic signed [MP_W-1:0] r30_sum, r16_sum;
  logic signed [CW-1:0]   r30;
  logic signed [39:0]     disp_x, disp_y;
  logic [ACC_W-1:0]       rnd_acc;
  logic [31:0]            turn;
  logic [31:0]            thr_sat;

  // a zero step acts as the smallest step
  assign ts = (sample_time == '0) ? ST_W'(1) : sample_time;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_ready = (state == S_IDLE);
  assign acc_in   = in_valid && in_ready;
  assign commit   = (state == S_FIN) && (!out_valid || out_ready);
  assign start_unit = acc_in && !func;

  assign diff     = 33'(speed) - 33'(lin_vel);
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  assign dividend = {diff_mag, {FRAC_BITS{1'b0}}};

  assign r30_sum = prod + (MP_W'(1) <<< 29);
  assign r30     = CW'(r30_sum >>> 30);
  assign r16_sum = prod + (MP_W'(1) <<< (FRAC_BITS - 1));
  assign disp_x  = 40'(pos_x) + 40'(r16_sum >>> FRAC_BITS);
  assign disp_y  = 40'(pos_y) + 40'(r16_sum >>> FRAC_BITS);

  // turn delta: round(|t| * rad_to_angle / 2^(2f)), sign put back afterwards
  assign rnd_acc = acc + (ACC_W'(1) << (2 * FRAC_BITS - 1));
  assign turn    = rnd_acc[2*FRAC_BITS +: 32];

  // throttle saturation on the quotient magnitude
  always_comb begin
    if (!d_neg) begin
      thr_sat = (quot > DIV_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : quot[31:0];
    end else begin
      thr_sat = (quot > DIV_W'(33'h080000000)) ? 32'h80000000 : 32'(-quot[31:0]);
    end
  end

  uos_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (start_unit),
    .angle (heading),
    .busy  (cor_busy),
    .cos_o (cos_v),
    .sin_o (sin_v)
  );

  uos_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (start_unit),
    .dividend (dividend),
    .divisor  (ts),
    .busy     (div_busy),
    .quotient (quot)
  );

  uos_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (acc_in) state_next = func ? S_FIN : S_ROT;
      S_ROT:   if (!cor_busy) state_next = S_M1;
      S_M1:    state_next = S_M2;
      S_M2:    state_next = S_M3;
      S_M3:    state_next = S_M4;
      S_M4:    state_next = S_M5;
      S_M5:    state_next = S_M6;
      S_M6:    state_next = S_M7;
      S_M7:    state_next = S_M8;
      S_M8:    state_next = S_M9;
      S_M9:    state_next = S_M10;
      S_M10:   state_next = S_WAIT;
      S_WAIT:  if (!div_busy) state_next = S_FIN;
      S_FIN:   if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // multiplier operand selection per sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_M1: begin
        mul_a = MA_W'(lin_vel);
        mul_b = MB_W'(cos_v);
      end
      S_M2: begin
        mul_a = MA_W'(lin_vel);
        mul_b = MB_W'(sin_v);
      end
      S_M3, S_M4: begin
        mul_a = px;
        mul_b = $signed(MB_W'(ts));
      end
      S_M5: begin
        mul_a = MA_W'(cmd_omega);
        mul_b = $signed(MB_W'(ts));
      end
      S_M7: begin
        mul_a = $signed(MA_W'(t_mag[31:0]));
        mul_b = $signed(RAD_TO_ANGLE);
      end
      S_M8: begin
        mul_a = $signed(MA_W'(t_mag[T_W-2:32]));
        mul_b = $signed(RAD_TO_ANGLE);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // control registers, configuration and pose state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      sample_time   <= TS_RESET;
      init_x        <= '0;
      init_y        <= '0;
      init_heading  <= '0;
      init_lin_vel  <= '0;
      init_ang_vel  <= '0;
      init_throttle <= '0;
      pos_x         <= '0;
      pos_y         <= '0;
      heading       <= '0;
      lin_vel       <= '0;
      ang_vel       <= '0;
      throttle      <= '0;
    end else begin
      state <= state_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr) begin
        case (paddr[4:2])
          REG_SAMPLE_TIME:   sample_time   <= pwdata[ST_W-1:0];
          REG_INIT_X:        init_x        <= pwdata;
          REG_INIT_Y:        init_y        <= pwdata;
          REG_INIT_HEADING:  init_heading  <= pwdata;
          REG_INIT_LIN_VEL:  init_lin_vel  <= pwdata;
          REG_INIT_ANG_VEL:  init_ang_vel  <= pwdata;
          REG_INIT_THROTTLE: init_throttle <= pwdata;
          default: ;
        endcase
      end
      // pose state doubles as the result payload, so it only moves at commit
      if (commit) begin
        if (restore) begin
          pos_x    <= init_x;
          pos_y    <= init_y;
          heading  <= init_heading;
          lin_vel  <= init_lin_vel;
          ang_vel  <= init_ang_vel;
          throttle <= init_throttle;
        end else begin
          pos_x    <= x_new;
          pos_y    <= y_new;
          heading  <= hd_new;
          lin_vel  <= cmd_speed;
          ang_vel  <= cmd_omega;
          throttle <= thr_sat;
        end
      end
    end
  end

  // datapath scratch registers
  always_ff @(posedge clk) begin
    if (acc_in) begin
      restore   <= func;
      cmd_speed <= speed;
      cmd_omega <= omega;
      d_neg     <= diff[32];
    end
    case (state)
      S_M2:  px    <= r30;
      S_M3:  px    <= r30;
      S_M4:  x_new <= sat32(disp_x);
      S_M5:  y_new <= sat32(disp_y);
      S_M6: begin
        t_neg <= prod[MP_W-1];
        t_mag <= prod[MP_W-1] ? (T_W-1)'(-prod[T_W-2:0]) : prod[T_W-2:0];
      end
      S_M8:  acc   <= ACC_W'(prod[61:0]);
      S_M9:  acc   <= acc + (ACC_W'(prod[47:0]) << 32);
      S_M10: hd_new <= heading + (t_neg ? 32'(-turn) : turn);
      default: ;
    endcase
  end

  // register readback
  always_comb begin
    case (paddr[4:2])
      REG_SAMPLE_TIME:   prdata = 32'(sample_time);
      REG_INIT_X:        prdata = init_x;
      REG_INIT_Y:        prdata = init_y;
      REG_INIT_HEADING:  prdata = init_heading;
      REG_INIT_LIN_VEL:  prdata = init_lin_vel;
      REG_INIT_ANG_VEL:  prdata = init_ang_vel;
      REG_INIT_THROTTLE: prdata = init_throttle;
      default:           prdata = '0;
    endcase
  end

endmodule

[rtl/uos_mul.sv]
// ----------------------------------------------------------------------------
// uos_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module uos_mul (
  input  logic                               clk,
  input  logic signed [uos_pkg::MA_W-1:0]    a,
  input  logic signed [uos_pkg::MB_W-1:0]    b,
  output logic signed [uos_pkg::MP_W-1:0]    prod
);
  import uos_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

[rtl/uos_cordic.sv]
// ----------------------------------------------------------------------------
// uos_cordic
// iterative rotation-mode cordic, one micro-rotation per cycle
// ----------------------------------------------------------------------------
module uos_cordic (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [31:0]                    angle,
  output logic                           busy,
  output logic signed [uos_pkg::CW-1:0]  cos_o,
  output logic signed [uos_pkg::CW-1:0]  sin_o
);
  import uos_pkg::*;

  logic signed [CW-1:0] x, y, z;
  logic [STEP_W-1:0]    step;
  logic                 flip;
  logic [4:0]           k;
  logic signed [CW-1:0] xs, ys, at;

  assign k  = step[4:0];
  assign xs = x >>> k;
  assign ys = y >>> k;
  assign at = $signed({{(CW-32){1'b0}}, atan_lut(k)});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && step == STEP_W'(CORDIC_STAGES - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      flip <= angle[31] ^ angle[30];
      x    <= $signed({{(CW-32){1'b0}}, CORDIC_GAIN_Q30});
      y    <= '0;
      z    <= $signed({{(CW-32){angle[31] ^ angle[31] ^ angle[30]}},
                       angle[31] ^ angle[30] ^ angle[31], angle[30:0]});
      step <= '0;
    end else if (busy) begin
      if (!z[CW-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
      step <= step + 1'b1;
    end
  end

  assign cos_o = flip ? -x : x;
  assign sin_o = flip ? -y : y;

endmodule

[rtl/uos_div.sv]
// ----------------------------------------------------------------------------
// uos_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module uos_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [uos_pkg::DIV_W-1:0]     dividend,
  input  logic [uos_pkg::ST_W-1:0]      divisor,
  output logic                          busy,
  output logic [uos_pkg::DIV_W-1:0]     quotient
);
  import uos_pkg::*;

  logic [ST_W-1:0]   dvs;
  logic [ST_W-1:0]   rem;
  logic [ST_W:0]     trial;
  logic              fits;
  logic [DCNT_W-1:0] cnt;

  assign trial = {rem, quotient[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == DCNT_W'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      cnt      <= DCNT_W'(DIV_W);
    end else if (busy) begin
      rem      <= fits ? ST_W'(trial - {1'b0, dvs}) : trial[ST_W-1:0];
      quotient <= {quotient[DIV_W-2:0], fits};
      cnt      <= cnt - 1'b1;
    end
  end

endmodule
